[rtl/csr_pkg.sv]
// Shared codes and types of the card stack with rotation.
`timescale 1ns / 1ps
`default_nettype none

package csr_pkg;

    // Command codes carried in the low bits of the input transaction
    localparam logic [2:0] CMD_PUSH        = 3'd0;
    localparam logic [2:0] CMD_POP         = 3'd1;
    localparam logic [2:0] CMD_TOP_TO_BOT  = 3'd2;
    localparam logic [2:0] CMD_BOT_TO_TOP  = 3'd3;
    localparam logic [2:0] CMD_LIST_TOP    = 3'd4;
    localparam logic [2:0] CMD_LIST_BOT    = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Fixed field widths
    localparam int CMD_W   = 3;
    localparam int CARD_W  = 32;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;

    // Widest card count the chain may carry (depth up to 64)
    localparam int CNT_MAX_W = 7;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CO_HOLD,
        CO_PUSH,
        CO_POP,
        CO_TOP_TO_BOT,
        CO_BOT_TO_TOP
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [CNT_MAX_W-1:0]   count;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/csr_cell.sv]
// One cell of the card chain: holds the card at a fixed depth below the top.
`timescale 1ns / 1ps
`default_nettype none

module csr_cell #(
    parameter int IDX = 0,
    parameter int SW  = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire csr_pkg::cell_ctrl_t ctrl,
    input  wire  [SW-1:0]          push_data,
    input  wire  [SW-1:0]          top_data,
    input  wire  [SW-1:0]          bottom_data,
    input  wire  [SW-1:0]          prev_data,
    input  wire  [SW-1:0]          next_data,
    output logic [SW-1:0]          data
);

    // 1-based depth of this cell
    localparam logic [csr_pkg::CNT_MAX_W-1:0] POS = csr_pkg::CNT_MAX_W'(IDX + 1);

    logic [SW-1:0] data_reg;
    logic [SW-1:0] data_next;

    // Pick the new card from a neighbour or a broadcast
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            csr_pkg::CO_PUSH:
            begin
                data_next = (IDX == 0) ? push_data : prev_data;
            end
            csr_pkg::CO_POP:
            begin
                data_next = next_data;
            end
            csr_pkg::CO_TOP_TO_BOT:
            begin
                if (POS < ctrl.count)
                    data_next = next_data;
                else if (POS == ctrl.count)
                    data_next = top_data;
            end
            csr_pkg::CO_BOT_TO_TOP:
            begin
                if (IDX == 0)
                    data_next = bottom_data;
                else if (POS <= ctrl.count)
                    data_next = prev_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Hold the card; payload needs no reset value
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

    // The reset is not used by the payload register
    logic unused_rst;
    assign unused_rst = rst_n;

endmodule

`default_nettype wire

[rtl/csr_ctrl.sv]
// Command sequencer, card count and result register of the card stack.
`timescale 1ns / 1ps
`default_nettype none

module csr_ctrl #(
    parameter int DEPTH = 32,
    parameter int SW    = 32,
    parameter int CNTW  = 6
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [csr_pkg::CMD_W-1:0]        cmd,
    input  wire  [SW-1:0]                    top_data,
    input  wire  [SW-1:0]                    bottom_data,
    output csr_pkg::cell_ctrl_t              cell_ctrl,
    output logic [CNTW-1:0]                  count,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [csr_pkg::STAT_W-1:0]       status,
    output logic [csr_pkg::CARD_W-1:0]       card_value,
    output logic [csr_pkg::POS_W-1:0]        position,
    output logic                             last
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_LIST
    } state_t;

    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);
    localparam logic [CNTW-1:0] ONE_CNT  = CNTW'(1);

    state_t                        state_reg, state_next;
    logic [CNTW-1:0]               count_reg, count_next;
    logic [CNTW-1:0]               left_reg, left_next;
    logic [csr_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                          dir_reg, dir_next;
    logic                          out_valid_reg, out_valid_next;
    logic [csr_pkg::STAT_W-1:0]    status_reg, status_next;
    logic [csr_pkg::CARD_W-1:0]    value_reg, value_next;
    logic [csr_pkg::POS_W-1:0]     position_reg, position_next;
    logic                          last_reg, last_next;

    logic                          out_free;
    logic                          accept;
    logic                          emit;
    csr_pkg::cell_op_t             op;
    logic [csr_pkg::CARD_W-1:0]    top_ext;
    logic [csr_pkg::CARD_W-1:0]    bottom_ext;

    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == S_IDLE) && out_free;
    assign accept     = in_valid && in_ready;
    assign top_ext    = csr_pkg::CARD_W'($signed(top_data));
    assign bottom_ext = csr_pkg::CARD_W'($signed(bottom_data));

    // Decode the command or advance the listing
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        pos_next      = pos_reg;
        dir_next      = dir_reg;
        op            = csr_pkg::CO_HOLD;
        emit          = 1'b0;
        status_next   = status_reg;
        value_next    = value_reg;
        position_next = position_reg;
        last_next     = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next   = csr_pkg::ST_OK;
                    value_next    = '0;
                    position_next = '0;
                    last_next     = 1'b1;
                    case (cmd)
                        csr_pkg::CMD_PUSH:
                        begin
                            emit = 1'b1;
                            if (count_reg == FULL_CNT)
                                status_next = csr_pkg::ST_FULL;
                            else
                            begin
                                op         = csr_pkg::CO_PUSH;
                                count_next = count_reg + ONE_CNT;
                            end
                        end
                        csr_pkg::CMD_POP:
                        begin
                            emit = 1'b1;
                            if (count_reg == '0)
                                status_next = csr_pkg::ST_EMPTY;
                            else
                            begin
                                op         = csr_pkg::CO_POP;
                                value_next = top_ext;
                                count_next = count_reg - ONE_CNT;
                            end
                        end
                        csr_pkg::CMD_TOP_TO_BOT,
                        csr_pkg::CMD_BOT_TO_TOP:
                        begin
                            emit = 1'b1;
                            if (count_reg == '0)
                                status_next = csr_pkg::ST_EMPTY;
                            else if (count_reg > ONE_CNT)
                                op = (cmd == csr_pkg::CMD_TOP_TO_BOT) ?
                                     csr_pkg::CO_TOP_TO_BOT : csr_pkg::CO_BOT_TO_TOP;
                        end
                        csr_pkg::CMD_LIST_TOP,
                        csr_pkg::CMD_LIST_BOT:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_LIST;
                                left_next  = count_reg;
                                pos_next   = csr_pkg::POS_W'(1);
                                dir_next   = (cmd == csr_pkg::CMD_LIST_BOT);
                            end
                        end
                        default:
                        begin
                            // unused codes give no result
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                // Emit the end card and rotate it round, one per cycle while the output is free
                if (out_free)
                begin
                    emit          = 1'b1;
                    status_next   = csr_pkg::ST_OK;
                    value_next    = dir_reg ? bottom_ext : top_ext;
                    position_next = pos_reg;
                    last_next     = (left_reg == ONE_CNT);
                    if (count_reg > ONE_CNT)
                        op = dir_reg ? csr_pkg::CO_BOT_TO_TOP : csr_pkg::CO_TOP_TO_BOT;
                    left_next = left_reg - ONE_CNT;
                    pos_next  = pos_reg + csr_pkg::POS_W'(1);
                    if (left_reg == ONE_CNT)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Hold state, count, listing counters and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            pos_reg       <= '0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            pos_reg       <= pos_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        value_reg    <= value_next;
        position_reg <= position_next;
        last_reg     <= last_next;
    end

    assign cell_ctrl  = {op, csr_pkg::CNT_MAX_W'(count_reg)};
    assign count      = count_reg;
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign card_value = value_reg;
    assign position   = position_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

[rtl/card_stack_with_rotation_core.sv]
// Top level of the card stack with rotation: sequencer and chain of card cells.
//
//  channel  | direction | tdata fields (lsb first)                  | tlast
//  ---------+-----------+-------------------------------------------+------------------
//  s_axis   | in        | cmd[2:0], card_id[34:3], zero pad [39:35] | -
//  m_axis   | out       | status[1:0], card_value[33:2], pos[39:34] | last result
//
// Push, pop and the rotates shift the chain of cells in the cycle the
// transaction is accepted, and the result is loaded into the output register
// at the same clock edge. A listing emits one result per cycle while the output
// is not stalled, rotating the chain by one card after each if it holds more than one.
// Reset clears the card count and sequencer; the cells need no clearing.
// A stalled output holds the sequencer, so no new command is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module card_stack_with_rotation_core #(
    parameter int DEPTH    = 32,
    parameter int ID_WIDTH = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // cmd[2:0], card_id[34:3], zero [39:35]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status[1:0], card_value[33:2], position[39:34]
    output logic        m_axis_tlast
);

    localparam int SW   = (ID_WIDTH < csr_pkg::CARD_W) ? ID_WIDTH : csr_pkg::CARD_W;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int IDXW = $clog2(DEPTH);

    csr_pkg::cell_ctrl_t             cell_ctrl;
    logic [CNTW-1:0]                 count;
    logic [CNTW-1:0]                 count_m1;
    logic [IDXW-1:0]                 bottom_idx;
    logic [SW-1:0]                   cell_q [DEPTH];
    logic [SW-1:0]                   push_data;
    logic [SW-1:0]                   bottom_data;
    logic [csr_pkg::STAT_W-1:0]      status;
    logic [csr_pkg::CARD_W-1:0]      card_value;
    logic [csr_pkg::POS_W-1:0]       position;
    logic                            unused_pad;

    assign push_data  = s_axis_tdata[csr_pkg::CMD_W +: SW];
    assign unused_pad = ^s_axis_tdata[39:csr_pkg::CMD_W + SW];

    // Select the bottom card, the one sitting at index count - 1
    assign count_m1    = count - CNTW'(1);
    assign bottom_idx  = count_m1[IDXW-1:0];
    assign bottom_data = cell_q[bottom_idx];

    csr_ctrl #(
        .DEPTH (DEPTH),
        .SW    (SW),
        .CNTW  (CNTW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .cmd         (s_axis_tdata[csr_pkg::CMD_W-1:0]),
        .top_data    (cell_q[0]),
        .bottom_data (bottom_data),
        .cell_ctrl   (cell_ctrl),
        .count       (count),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .status      (status),
        .card_value  (card_value),
        .position    (position),
        .last        (m_axis_tlast)
    );

    // Build the chain: each cell talks to the cells above and below it
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [SW-1:0] prev_d;
        logic [SW-1:0] next_d;

        if (i == 0)
        begin : g_first
            assign prev_d = push_data;
        end
        else
        begin : g_mid
            assign prev_d = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_d = cell_q[i];
        end
        else
        begin : g_inner
            assign next_d = cell_q[i+1];
        end

        csr_cell #(
            .IDX (i),
            .SW  (SW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .push_data   (push_data),
            .top_data    (cell_q[0]),
            .bottom_data (bottom_data),
            .prev_data   (prev_d),
            .next_data   (next_d),
            .data        (cell_q[i])
        );
    end

    // Pack the result transaction
    assign m_axis_tdata = {position, card_value, status};

endmodule

`default_nettype wire
